// ===== src/ptdt_pkg.sv =====
// Shared types and constants of the periodic task due table.
package ptdt_pkg;

  localparam int CMD_W       = 2;
  localparam int PERIOD_W    = 16;
  localparam int TARGET_W    = 3;
  localparam int STATUS_W    = 2;
  localparam int SLOT_W      = 3;
  localparam int COUNT_W     = 4;
  localparam int OVR_W       = 32;
  localparam int MAX_RESULTS = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_RUN    = 2'd1,
    CMD_ADD    = 2'd2,
    CMD_ENABLE = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK          = 2'd0,
    STATUS_ZERO_PERIOD = 2'd1,
    STATUS_FULL        = 2'd2,
    STATUS_NOT_USED    = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic idx_clr;
    logic idx_inc;
    logic tick_wr;
    logic run_emit;
    logic resp_emit;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_e command;
    logic used_zero;
    logic any_pending;
    logic idx_at_end;
    logic run_hit;
    logic run_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== src/ptdt_if.sv =====
// Input and result channel interfaces of the periodic task due table.
interface ptdt_in_if;
  logic                          valid;
  logic                          ready;
  logic [ptdt_pkg::CMD_W-1:0]    command;
  logic [ptdt_pkg::PERIOD_W-1:0] period;
  logic [ptdt_pkg::TARGET_W-1:0] target_slot;
  logic                          enable_flag;

  modport source (output valid, command, period, target_slot, enable_flag, input ready);
  modport sink   (input valid, command, period, target_slot, enable_flag, output ready);
endinterface

interface ptdt_out_if;
  logic                          valid;
  logic                          ready;
  logic [ptdt_pkg::STATUS_W-1:0] status;
  logic [ptdt_pkg::SLOT_W-1:0]   slot;
  logic                          task_ran;
  logic [ptdt_pkg::COUNT_W-1:0]  ran_count;
  logic [ptdt_pkg::OVR_W-1:0]    overrun_count;
  logic                          last;

  modport source (output valid, status, slot, task_ran, ran_count, overrun_count, last,
                  input ready);
  modport sink   (input valid, status, slot, task_ran, ran_count, overrun_count, last,
                  output ready);
endinterface

// ===== src/periodic_task_due_table.sv =====
// Top level of the periodic task due table.
//
//   channel  dir  handshake      payload
//   in_i     in   valid / ready  command, period, target_slot, enable_flag
//   out_o    out  valid / ready  status, slot, task_ran, ran_count, overrun_count, last
//
// One input word is in work at a time; ready is high only while idle.
// Add and enable: accept, then the result word.
// Tick: accept, then for each slot in use a read state and a write state
//   on the counter table (registered read port), then the result word.
// Run: accept, then a single result word when nothing is due; otherwise
//   accept, then a scan of the slots up to the last one that runs (at most
//   slots_used), one result word per slot that runs; a stall on out_o holds
//   the scan at a slot that runs.
// Reset clears flags, fill count and overrun counter; the period and counter
//   tables need no clearing since only slots below the fill count are read.
module periodic_task_due_table #(
  parameter int NUM_TASKS   = 8,
  parameter int PERIOD_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptdt_in_if.sink     in_i,
  ptdt_out_if.source  out_o
);

  ptdt_pkg::ctrl_cmd_t ctrl_cmd;
  ptdt_pkg::ctrl_sts_t ctrl_sts;
  logic                in_ready;

  assign in_i.ready = in_ready;

  ptdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (ctrl_sts),
    .cmd_o      (ctrl_cmd)
  );

  ptdt_dpath #(
    .NUM_TASKS   (NUM_TASKS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .command_i     (in_i.command),
    .period_i      (in_i.period),
    .target_slot_i (in_i.target_slot),
    .enable_flag_i (in_i.enable_flag),
    .cmd_i         (ctrl_cmd),
    .sts_o         (ctrl_sts),
    .out_o         (out_o)
  );

endmodule

// ===== src/ptdt_dpath.sv =====
// Datapath: slot tables, due/enable flags, overrun counter and result register.
module ptdt_dpath #(
  parameter int NUM_TASKS   = 8,
  parameter int PERIOD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ptdt_pkg::CMD_W-1:0]    command_i,
  input  logic [ptdt_pkg::PERIOD_W-1:0] period_i,
  input  logic [ptdt_pkg::TARGET_W-1:0] target_slot_i,
  input  logic                          enable_flag_i,
  input  ptdt_pkg::ctrl_cmd_t           cmd_i,
  output ptdt_pkg::ctrl_sts_t           sts_o,
  ptdt_out_if.source                    out_o
);

  localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int UW = $clog2(NUM_TASKS + 1);

  // period and counter tables, each with a write port and a read port at the sweep index
  logic [PERIOD_BITS-1:0] per_mem [NUM_TASKS];
  logic [PERIOD_BITS-1:0] cnt_mem [NUM_TASKS];
  logic [PERIOD_BITS-1:0] per_rd_q, cnt_rd_q;

  logic [UW-1:0]               used_q, used_d;
  logic [NUM_TASKS-1:0]        due_q, due_d, en_q, en_d;
  logic [ptdt_pkg::OVR_W-1:0]  ovr_q, ovr_d;
  logic [IW-1:0]               idx_q, idx_d;
  logic [ptdt_pkg::COUNT_W-1:0] n_q, n_d;

  logic [ptdt_pkg::STATUS_W-1:0] resp_status_q, resp_status_d;
  logic [ptdt_pkg::SLOT_W-1:0]   resp_slot_q, resp_slot_d;

  logic                           out_valid_q, out_valid_d;
  logic [ptdt_pkg::STATUS_W-1:0]  out_status_q;
  logic [ptdt_pkg::SLOT_W-1:0]    out_slot_q;
  logic                           out_ran_q;
  logic [ptdt_pkg::COUNT_W-1:0]   out_cnt_q;
  logic [ptdt_pkg::OVR_W-1:0]     out_ovr_q;
  logic                           out_last_q;

  ptdt_pkg::cmd_e         cmd_in;
  logic [PERIOD_BITS-1:0] per_in;
  logic                   per_zero, full, tgt_bad, add_do, en_do;
  logic [IW-1:0]          add_idx, tgt_idx;
  logic [NUM_TASKS-1:0]   pending, above;
  logic                   out_free, run_hit, run_last;
  logic [PERIOD_BITS-1:0] c_inc, c_new;
  logic                   c_hit, tick_act;
  logic                   cnt_we;
  logic [IW-1:0]          cnt_wa;
  logic [PERIOD_BITS-1:0] cnt_wd;

  always_comb begin
    cmd_in   = ptdt_pkg::cmd_e'(command_i);
    per_in   = PERIOD_BITS'(period_i);
    per_zero = (per_in == '0);
    full     = (used_q == UW'(NUM_TASKS));
    tgt_bad  = (8'(target_slot_i) >= 8'(used_q));
    add_idx  = used_q[IW-1:0];
    tgt_idx  = IW'(target_slot_i);
    add_do   = cmd_i.accept && (cmd_in == ptdt_pkg::CMD_ADD) && !per_zero && !full;
    en_do    = cmd_i.accept && (cmd_in == ptdt_pkg::CMD_ENABLE) && !tgt_bad;

    pending = due_q & en_q;
    for (int j = 0; j < NUM_TASKS; j++) begin
      above[j] = (j > int'(idx_q));
    end
    run_hit  = pending[idx_q];
    run_last = (n_q == ptdt_pkg::COUNT_W'(ptdt_pkg::MAX_RESULTS - 1)) ||
               ((pending & above) == '0);
    out_free = !out_valid_q || out_o.ready;

    // tick update of the slot under the sweep index
    c_inc    = cnt_rd_q + PERIOD_BITS'(1);
    c_hit    = (c_inc >= per_rd_q);
    c_new    = c_hit ? (c_inc - per_rd_q) : c_inc;
    tick_act = cmd_i.tick_wr && en_q[idx_q];

    cnt_we = add_do || en_do || tick_act;
    cnt_wa = cmd_i.tick_wr ? idx_q : (add_do ? add_idx : tgt_idx);
    cnt_wd = cmd_i.tick_wr ? c_new : '0;
  end

  // single-word response computed at accept
  always_comb begin
    resp_status_d = resp_status_q;
    resp_slot_d   = resp_slot_q;
    if (cmd_i.accept) begin
      resp_status_d = ptdt_pkg::STATUS_OK;
      resp_slot_d   = '0;
      case (cmd_in)
        ptdt_pkg::CMD_TICK, ptdt_pkg::CMD_RUN: begin
          resp_status_d = ptdt_pkg::STATUS_OK;
        end
        ptdt_pkg::CMD_ADD: begin
          if (per_zero) begin
            resp_status_d = ptdt_pkg::STATUS_ZERO_PERIOD;
          end else if (full) begin
            resp_status_d = ptdt_pkg::STATUS_FULL;
          end else begin
            resp_slot_d = ptdt_pkg::SLOT_W'(used_q);
          end
        end
        ptdt_pkg::CMD_ENABLE: begin
          resp_slot_d = target_slot_i;
          if (tgt_bad) resp_status_d = ptdt_pkg::STATUS_NOT_USED;
        end
        default: begin
          resp_status_d = ptdt_pkg::STATUS_OK;
        end
      endcase
    end
  end

  always_comb begin
    used_d = used_q;
    due_d  = due_q;
    en_d   = en_q;
    ovr_d  = ovr_q;
    idx_d  = idx_q;
    n_d    = n_q;
    if (add_do) begin
      used_d           = used_q + UW'(1);
      en_d[add_idx]    = 1'b1;
      due_d[add_idx]   = 1'b0;
    end
    if (en_do) begin
      en_d[tgt_idx]  = enable_flag_i;
      due_d[tgt_idx] = 1'b0;
    end
    if (tick_act && c_hit) begin
      if (due_q[idx_q]) ovr_d = ovr_q + ptdt_pkg::OVR_W'(1);
      else              due_d[idx_q] = 1'b1;
    end
    if (cmd_i.run_emit) begin
      due_d[idx_q] = 1'b0;
      n_d          = n_q + ptdt_pkg::COUNT_W'(1);
    end
    if (cmd_i.idx_clr) begin
      idx_d = '0;
      n_d   = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.resp_emit || cmd_i.run_emit) out_valid_d = 1'b1;
    else if (out_o.ready)                   out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      due_q       <= '0;
      en_q        <= '0;
      ovr_q       <= '0;
      idx_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      used_q      <= used_d;
      due_q       <= due_d;
      en_q        <= en_d;
      ovr_q       <= ovr_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    resp_status_q <= resp_status_d;
    resp_slot_q   <= resp_slot_d;
    if (cmd_i.run_emit) begin
      out_status_q <= ptdt_pkg::STATUS_OK;
      out_slot_q   <= ptdt_pkg::SLOT_W'(idx_q);
      out_ran_q    <= 1'b1;
      out_cnt_q    <= n_q + ptdt_pkg::COUNT_W'(1);
      out_ovr_q    <= ovr_q;
      out_last_q   <= run_last;
    end else if (cmd_i.resp_emit) begin
      out_status_q <= resp_status_q;
      out_slot_q   <= resp_slot_q;
      out_ran_q    <= 1'b0;
      out_cnt_q    <= '0;
      out_ovr_q    <= ovr_q;
      out_last_q   <= 1'b1;
    end
  end

  // tables: registered read at the sweep index
  always_ff @(posedge clk_i) begin
    if (add_do) per_mem[add_idx] <= per_in;
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    per_rd_q <= per_mem[idx_q];
    cnt_rd_q <= cnt_mem[idx_q];
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.slot          = out_slot_q;
  assign out_o.task_ran      = out_ran_q;
  assign out_o.ran_count     = out_cnt_q;
  assign out_o.overrun_count = out_ovr_q;
  assign out_o.last          = out_last_q;

  always_comb begin
    sts_o.command     = cmd_in;
    sts_o.used_zero   = (used_q == '0);
    sts_o.any_pending = (pending != '0);
    sts_o.idx_at_end  = (UW'(idx_q) + UW'(1) == used_q);
    sts_o.run_hit     = run_hit;
    sts_o.run_last    = run_last;
    sts_o.out_free    = out_free;
  end

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(NUM_TASKS))
    else $error("fill count beyond table size");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.run_emit || cmd_i.resp_emit) |-> out_free)
    else $error("result word overwritten while held");

  a_ovr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovr_q != $past(ovr_q)) |-> (ovr_q == $past(ovr_q) + ptdt_pkg::OVR_W'(1)))
    else $error("overrun counter jumped");

endmodule

// ===== src/ptdt_ctrl.sv =====
// Controller: sequences accept, tick sweep, run scan and response words.
module ptdt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ptdt_pkg::ctrl_sts_t sts_i,
  output ptdt_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_TICK_RD = 5'b00010,
    S_TICK_WR = 5'b00100,
    S_RUN     = 5'b01000,
    S_RESP    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept  = 1'b1;
          cmd_o.idx_clr = 1'b1;
          case (sts_i.command)
            ptdt_pkg::CMD_TICK:  state_d = sts_i.used_zero ? S_RESP : S_TICK_RD;
            ptdt_pkg::CMD_RUN:   state_d = sts_i.any_pending ? S_RUN : S_RESP;
            default:             state_d = S_RESP;
          endcase
        end
      end
      S_TICK_RD: begin
        state_d = S_TICK_WR;
      end
      S_TICK_WR: begin
        cmd_o.tick_wr = 1'b1;
        if (sts_i.idx_at_end) begin
          state_d = S_RESP;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_TICK_RD;
        end
      end
      S_RUN: begin
        if (!sts_i.run_hit) begin
          cmd_o.idx_inc = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.run_emit = 1'b1;
          if (sts_i.run_last) state_d = S_IDLE;
          else                cmd_o.idx_inc = 1'b1;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.resp_emit = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> !in_ready_o)
    else $error("second word taken while one is in work");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.run_emit && sts_i.run_last) |=> (state_q == S_IDLE))
    else $error("run scan did not end on its last word");

  a_tick_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TICK_WR && sts_i.idx_at_end) |=> (state_q == S_RESP))
    else $error("tick sweep did not end at the fill count");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench of the periodic task due table.
module tb;

  // Run length and watchdog. The slowest legal word is a run that emits eight
  // words, each held up by a receiver stall, behind a sender gap. Some 360
  // words are sent in all.
  localparam int RANDOM_WORDS = 334;
  localparam int CALM_TAIL    = 30;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int NUM_SLOTS    = 8;
  localparam int PRINT_CAP    = 50;

  typedef logic [ptdt_pkg::PERIOD_W-1:0] period_t;
  typedef logic [ptdt_pkg::TARGET_W-1:0] target_t;

  // One command word, plus a flag that makes the driver hold it back until
  // every outstanding result word has been seen.
  typedef struct {
    ptdt_pkg::cmd_e                  command;
    logic [ptdt_pkg::PERIOD_W-1:0]   period;
    logic [ptdt_pkg::TARGET_W-1:0]   target_slot;
    logic                            enable_flag;
    bit                              hold;
  } cmd_word_t;

  typedef struct {
    ptdt_pkg::status_e               status;
    logic [ptdt_pkg::SLOT_W-1:0]     slot;
    logic                            task_ran;
    logic [ptdt_pkg::COUNT_W-1:0]    ran_count;
    logic [ptdt_pkg::OVR_W-1:0]      overrun_count;
    logic                            last;
  } result_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ptdt_in_if  in_if ();
  ptdt_out_if out_if ();

  periodic_task_due_table u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the slot table, kept in step with accepted command words.
  logic [ptdt_pkg::PERIOD_W-1:0] tbl_period [NUM_SLOTS];
  logic [ptdt_pkg::PERIOD_W-1:0] tbl_count  [NUM_SLOTS];
  logic                          tbl_due    [NUM_SLOTS];
  logic                          tbl_en     [NUM_SLOTS];
  int unsigned                   tbl_fill;
  logic [ptdt_pkg::OVR_W-1:0]    tbl_overruns;

  cmd_word_t    cmd_q[$];            // words still to be sent
  result_word_t sched_results_q[$];  // result words predicted, not yet seen
  cmd_word_t    cur_word;            // word on the input bus

  int words_total;
  int words_taken;
  int results_seen;
  int runs_seen;
  int err_count;
  int gap_left;
  int stall_left;
  int send_odds;
  int recv_odds;
  int cycle_count;

  task automatic note_mismatch(input string msg);
    if (err_count < PRINT_CAP) begin
      $display("tb: mismatch at %0d: %s", cycle_count, msg);
    end
    err_count++;
  endtask

  function automatic result_word_t mk_result(ptdt_pkg::status_e st, int unsigned sl,
                                             logic ran, int unsigned cnt, logic lst);
    result_word_t r;
    r.status        = st;
    r.slot          = sl[ptdt_pkg::SLOT_W-1:0];
    r.task_ran      = ran;
    r.ran_count     = cnt[ptdt_pkg::COUNT_W-1:0];
    r.overrun_count = tbl_overruns;
    r.last          = lst;
    return r;
  endfunction

  // Apply one accepted word to the shadow table and queue its result words.
  task automatic schedule_step(input cmd_word_t w);
    result_word_t ran_q[$];
    result_word_t r;
    int unsigned  tgt;
    case (w.command)
      ptdt_pkg::CMD_TICK: begin
        for (int i = 0; i < tbl_fill; i++) begin
          if (tbl_en[i]) begin
            tbl_count[i] = tbl_count[i] + 1'b1;   // wraps at the period width
            if (tbl_count[i] >= tbl_period[i]) begin
              tbl_count[i] = tbl_count[i] - tbl_period[i];   // keeps the phase
              if (tbl_due[i]) begin
                tbl_overruns = tbl_overruns + 1'b1;
              end else begin
                tbl_due[i] = 1'b1;
              end
            end
          end
        end
        sched_results_q.push_back(mk_result(ptdt_pkg::STATUS_OK, 0, 1'b0, 0, 1'b1));
      end
      ptdt_pkg::CMD_RUN: begin
        for (int i = 0; i < tbl_fill && ran_q.size() < ptdt_pkg::MAX_RESULTS; i++) begin
          if (tbl_due[i] && tbl_en[i]) begin
            tbl_due[i] = 1'b0;
            ran_q.push_back(mk_result(ptdt_pkg::STATUS_OK, i, 1'b1, ran_q.size() + 1,
                                      1'b0));
          end
        end
        if (ran_q.size() == 0) begin
          sched_results_q.push_back(mk_result(ptdt_pkg::STATUS_OK, 0, 1'b0, 0, 1'b1));
        end else begin
          ran_q[ran_q.size()-1].last = 1'b1;
          foreach (ran_q[k]) sched_results_q.push_back(ran_q[k]);
        end
      end
      ptdt_pkg::CMD_ADD: begin
        // zero period wins over a full table
        if (w.period == '0) begin
          r = mk_result(ptdt_pkg::STATUS_ZERO_PERIOD, 0, 1'b0, 0, 1'b1);
        end else if (tbl_fill >= NUM_SLOTS) begin
          r = mk_result(ptdt_pkg::STATUS_FULL, 0, 1'b0, 0, 1'b1);
        end else begin
          tbl_period[tbl_fill] = w.period;
          tbl_count[tbl_fill]  = '0;
          tbl_due[tbl_fill]    = 1'b0;
          tbl_en[tbl_fill]     = 1'b1;
          r = mk_result(ptdt_pkg::STATUS_OK, tbl_fill, 1'b0, 0, 1'b1);
          tbl_fill++;
        end
        sched_results_q.push_back(r);
      end
      default: begin
        tgt = 32'(w.target_slot);
        if (tgt >= tbl_fill) begin
          r = mk_result(ptdt_pkg::STATUS_NOT_USED, tgt, 1'b0, 0, 1'b1);
        end else begin
          tbl_count[tgt] = '0;
          tbl_due[tgt]   = 1'b0;
          tbl_en[tgt]    = w.enable_flag;
          r = mk_result(ptdt_pkg::STATUS_OK, tgt, 1'b0, 0, 1'b1);
        end
        sched_results_q.push_back(r);
      end
    endcase
  endtask

  task automatic check_result_word();
    result_word_t want;
    if (sched_results_q.size() == 0) begin
      note_mismatch($sformatf("unexpected word, status %0d slot %0d",
                              out_if.status, out_if.slot));
    end else begin
      want = sched_results_q.pop_front();
      if (out_if.status !== want.status)
        note_mismatch($sformatf("status %0d, want %0d", out_if.status, want.status));
      if (out_if.slot !== want.slot)
        note_mismatch($sformatf("slot %0d, want %0d", out_if.slot, want.slot));
      if (out_if.task_ran !== want.task_ran)
        note_mismatch($sformatf("task_ran %0b, want %0b", out_if.task_ran, want.task_ran));
      if (out_if.ran_count !== want.ran_count)
        note_mismatch($sformatf("ran_count %0d, want %0d", out_if.ran_count, want.ran_count));
      if (out_if.overrun_count !== want.overrun_count)
        note_mismatch($sformatf("overrun_count %0d, want %0d",
                                out_if.overrun_count, want.overrun_count));
      if (out_if.last !== want.last)
        note_mismatch($sformatf("last %0b, want %0b", out_if.last, want.last));
      if (want.task_ran) runs_seen++;
    end
    results_seen++;
  endtask

  function automatic int pick_odds();
    // 0 means no idling in this stretch; otherwise one chance in odds per word
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return 10;
    endcase
  endfunction

  function automatic cmd_word_t mk_word(ptdt_pkg::cmd_e c, period_t per,
                                        target_t tgt, logic en, bit hold);
    cmd_word_t w;
    w.command     = c;
    w.period      = per;
    w.target_slot = tgt;
    w.enable_flag = en;
    w.hold        = hold;
    return w;
  endfunction

  // Random word: mostly ticks and runs so that several slots fall due at once,
  // some enables (mostly re-enabling), and a few adds that probe zero and full.
  function automatic cmd_word_t rand_word();
    cmd_word_t   w;
    int unsigned pick;
    w = mk_word(ptdt_pkg::CMD_TICK, period_t'($urandom_range(0, 16'hFFFF)),
                target_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                ($urandom_range(0, 99) < 3));
    pick = $urandom_range(0, 99);
    if (pick < 48) begin
      w.command = ptdt_pkg::CMD_TICK;
    end else if (pick < 75) begin
      w.command = ptdt_pkg::CMD_RUN;
    end else if (pick < 88) begin
      w.command     = ptdt_pkg::CMD_ENABLE;
      w.enable_flag = ($urandom_range(0, 3) != 0);
    end else begin
      w.command = ptdt_pkg::CMD_ADD;
      case ($urandom_range(0, 9))
        0:       w.period = '0;
        1, 2:    w.period = period_t'($urandom_range(0, 16'hFFFF));
        default: w.period = period_t'($urandom_range(1, 12));
      endcase
    end
    return w;
  endfunction

  // Driver: presents queued words, keeps valid up back to back, and inserts
  // idle bursts between words. A held word waits for the result queue to drain.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.command     <= ptdt_pkg::CMD_TICK;
      in_if.period      <= '0;
      in_if.target_slot <= '0;
      in_if.enable_flag <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        schedule_step(cur_word);
        words_taken++;
        if (words_taken % 48 == 0) send_odds = pick_odds();
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (cmd_q.size() != 0 &&
                     !(cmd_q[0].hold && sched_results_q.size() != 0)) begin
          cur_word = cmd_q.pop_front();
          in_if.valid       <= 1'b1;
          in_if.command     <= cur_word.command;
          in_if.period      <= cur_word.period;
          in_if.target_slot <= cur_word.target_slot;
          in_if.enable_flag <= cur_word.enable_flag;
          if (cmd_q.size() > CALM_TAIL && send_odds != 0 &&
              $urandom_range(1, send_odds) == 1) begin
            gap_left = $urandom_range(1, 13);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result word and stalls in random bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        check_result_word();
        if (results_seen % 40 == 0) recv_odds = pick_odds();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (cmd_q.size() > CALM_TAIL && recv_odds != 0 &&
                   $urandom_range(1, recv_odds) == 1) begin
        stall_left = $urandom_range(0, 12);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: watchdog expired, %0d words taken, %0d results waiting",
               words_taken, sched_results_q.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tbl_period[i] = '0;
      tbl_count[i]  = '0;
      tbl_due[i]    = 1'b0;
      tbl_en[i]     = 1'b0;
    end
    tbl_fill     = 0;
    tbl_overruns = '0;
    words_taken  = 0;
    results_seen = 0;
    runs_seen    = 0;
    err_count    = 0;
    cycle_count  = 0;
    send_odds    = 3;
    recv_odds    = 3;

    // Directed opening: empty table, zero period, fill order, overrun,
    // multi-slot run, disable/re-enable, slot not in use, full table.
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_TICK, 16'h0000, 3'd0, 1'b0, 1'b0));
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_RUN, 16'hFFFF, 3'd7, 1'b1, 1'b0));
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_ENABLE, 16'h0000, 3'd0, 1'b1, 1'b0)); // table empty
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_ADD, 16'h0000, 3'd0, 1'b0, 1'b0)); // zero period
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_ADD, 16'h0001, 3'd0, 1'b0, 1'b0));
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_ADD, 16'hFFFF, 3'd7, 1'b1, 1'b0)); // longest period
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_ADD, 16'h0003, 3'd0, 1'b0, 1'b0));
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_TICK, 16'h0000, 3'd0, 1'b0, 1'b0));
    // overrun on slot 0
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_TICK, 16'h0000, 3'd0, 1'b0, 1'b0));
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_RUN, 16'h0000, 3'd0, 1'b0, 1'b0));
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_TICK, 16'h0000, 3'd0, 1'b0, 1'b0));
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_TICK, 16'h0000, 3'd0, 1'b0, 1'b0));
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_RUN, 16'h0000, 3'd0, 1'b0, 1'b0)); // two slots run
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_ENABLE, 16'h0000, 3'd0, 1'b0, 1'b0)); // disable 0
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_ENABLE, 16'hFFFF, 3'd7, 1'b0, 1'b0)); // not in use
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_ENABLE, 16'h0000, 3'd1, 1'b1, 1'b0));
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_TICK, 16'h0000, 3'd0, 1'b0, 1'b0));
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_RUN, 16'h0000, 3'd0, 1'b0, 1'b0));
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_ADD, 16'h0002, 3'd0, 1'b0, 1'b1)); // waits for drain
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_ADD, 16'h0004, 3'd0, 1'b0, 1'b0));
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_ADD, 16'h0005, 3'd0, 1'b0, 1'b0));
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_ADD, 16'h0006, 3'd0, 1'b0, 1'b0));
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_ADD, 16'h0007, 3'd0, 1'b0, 1'b0)); // table now full
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_ADD, 16'h8000, 3'd0, 1'b0, 1'b0)); // full
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_ADD, 16'h0000, 3'd0, 1'b0, 1'b0)); // zero beats full
    cmd_q.push_back(mk_word(ptdt_pkg::CMD_ENABLE, 16'h0000, 3'd0, 1'b1, 1'b0));

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      cmd_q.push_back(rand_word());
    end
    cmd_q[cmd_q.size() - RANDOM_WORDS].hold = 1'b1;   // drain before random part
    words_total = cmd_q.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Sample at the falling edge so the counters are settled.
    while (!(words_taken == words_total && sched_results_q.size() == 0)) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sched_results_q.size() != 0) begin
      note_mismatch($sformatf("%0d result words never arrived", sched_results_q.size()));
    end

    $display("tb: %0d command words, %0d result words checked", words_taken, results_seen);
    $display("tb: %0d task runs, %0d overruns, %0d mismatches",
             runs_seen, tbl_overruns, err_count);
    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
